/* design/tcp_option_value_extractor_unit_assert.svh */
// Assertion macros shared by the TCP option value extractor.
`ifndef TCP_OPTION_VALUE_EXTRACTOR_UNIT_ASSERT_SVH
`define TCP_OPTION_VALUE_EXTRACTOR_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TOVE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TOVE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tove_pkg.sv */
// Types and constants shared by the TCP option value extractor modules.
`timescale 1ns / 1ps

package tove_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CfgOptionKind = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgEtherType  = 2'd1;

  localparam logic [7:0]  ResetOptionKind = 8'd253;
  localparam logic [15:0] ResetEtherType  = 16'h0800;

  // Protocol constants.
  localparam logic [7:0] VersionMask    = 8'hF0;
  localparam logic [7:0] Version4       = 8'h40;
  localparam logic [7:0] TcpProtoNumber = 8'd6;
  localparam logic [7:0] AckMask        = 8'h10;
  localparam logic [5:0] MinHeaderBytes = 6'd20;
  localparam logic [7:0] FixedTcpBytes  = 8'd20;
  localparam logic [7:0] OptEol         = 8'd0;
  localparam logic [7:0] OptNop         = 8'd1;
  localparam logic [7:0] OptionMinLen   = 8'd2;
  localparam logic [7:0] ValueOptionLen = 8'd10;

  // Queue between the classifier and the parser; a power of two.
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    ClsOther,
    ClsEthHi,
    ClsEthLo,
    ClsVerIhl,
    ClsProto,
    ClsAddr,
    ClsL4
  } byte_class_e;

  typedef enum logic [2:0] {
    PhHeader,
    PhKind,
    PhLen,
    PhSkip,
    PhValue,
    PhDone
  } phase_e;

  typedef enum logic [2:0] {
    StFound     = 3'd0,
    StNotIpv4   = 3'd1,
    StNotTcp    = 3'd2,
    StBadOffset = 3'd3,
    StNoAck     = 3'd4,
    StAbsent    = 3'd5,
    StTruncated = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [7:0]  offset;
    byte_class_e cls;
  } queue_item_t;

  typedef struct packed {
    logic [7:0]  option_kind;
    logic [15:0] ether_type;
  } cfg_t;

  // The first member is the most significant; status lands in the low bits.
  typedef struct packed {
    logic [31:0] denominator;
    logic [31:0] numerator;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
    status_e     status;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned TdataW  = ((ResultW + 7) / 8) * 8;

endpackage

/* design/tove_front.sv */
// Ingress stage: numbers each frame byte and tags its header role.
`timescale 1ns / 1ps

module tove_front import tove_pkg::*; #(
  parameter int unsigned L2_HEADER_BYTES = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output queue_item_t push_item_o
);

  localparam logic [7:0] EthHiOff  = 8'(L2_HEADER_BYTES - 2);
  localparam logic [7:0] EthLoOff  = 8'(L2_HEADER_BYTES - 1);
  localparam logic [7:0] VerOff    = 8'(L2_HEADER_BYTES);
  localparam logic [7:0] ProtoOff  = 8'(L2_HEADER_BYTES + 9);
  localparam logic [7:0] AddrFirst = 8'(L2_HEADER_BYTES + 12);
  localparam logic [7:0] AddrLast  = 8'(L2_HEADER_BYTES + 19);
  localparam logic [7:0] L4First   = 8'(L2_HEADER_BYTES + 20);

  logic [7:0]  offset_q, offset_d;
  byte_class_e cls;
  logic        accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // Only fixed positions are known here; TCP positions depend on the IHL.
  always_comb begin
    if (offset_q == EthHiOff) begin
      cls = ClsEthHi;
    end else if (offset_q == EthLoOff) begin
      cls = ClsEthLo;
    end else if (offset_q == VerOff) begin
      cls = ClsVerIhl;
    end else if (offset_q == ProtoOff) begin
      cls = ClsProto;
    end else if (offset_q >= AddrFirst && offset_q <= AddrLast) begin
      cls = ClsAddr;
    end else if (offset_q >= L4First) begin
      cls = ClsL4;
    end else begin
      cls = ClsOther;
    end
  end

  always_comb begin
    push_item_o.data   = in_data_i;
    push_item_o.last   = in_last_i;
    push_item_o.offset = offset_q;
    push_item_o.cls    = cls;
  end

  // The offset saturates at 255 and restarts after the final byte.
  always_comb begin
    offset_d = offset_q;
    if (accept) begin
      if (in_last_i) begin
        offset_d = '0;
      end else if (offset_q != 8'hFF) begin
        offset_d = offset_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else begin
      offset_q <= offset_d;
    end
  end

endmodule

/* design/tove_fifo.sv */
// Short queue that decouples the ingress stage from the parser.
`timescale 1ns / 1ps

module tove_fifo import tove_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  output logic        wr_ready_o,
  input  queue_item_t wr_item_i,
  output logic        rd_valid_o,
  input  logic        rd_ready_i,
  output queue_item_t rd_item_o
);

  localparam int unsigned PtrW   = $clog2(QueueDepth);
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  queue_item_t            slots_q [QueueDepth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0]      count_q;
  logic                   do_push, do_pop;

  assign wr_ready_o = (count_q != CountW'(QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = slots_q[rd_ptr_q];
  assign do_push    = wr_valid_i && wr_ready_o;
  assign do_pop     = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

endmodule

/* design/tove_parser.sv */
// Parser: header checks, TCP option walk and the result register.
`timescale 1ns / 1ps

module tove_parser import tove_pkg::*; #(
  parameter int unsigned L2_HEADER_BYTES  = 14,
  parameter int unsigned MAX_OPTION_STEPS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  queue_item_t item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_o
);

  localparam int unsigned StepW = $clog2(MAX_OPTION_STEPS + 1);

  phase_e            phase_q, phase_d;
  status_e           verdict_q, verdict_d;
  logic [7:0]        kind_q, kind_d;
  logic [7:0]        tcp_off_q, tcp_off_d;
  logic [7:0]        hdr_end_q, hdr_end_d;
  logic [7:0]        next_off_q, next_off_d;
  logic [StepW-1:0]  steps_q, steps_d, steps_inc;
  logic [63:0]       addr_q, addr_d;
  logic [31:0]       ports_q, ports_d;
  logic [63:0]       value_q, value_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              out_free, pop, frame_end;
  logic [7:0]        b, p, tcp_rel, room;
  logic [5:0]        ihl_bytes, thb_bytes;
  status_e           status;

  // Next step of the option walk: it stops at the header end or the step limit.
  function automatic phase_e walk_phase(input logic [7:0] off,
                                        input logic [StepW-1:0] steps,
                                        input logic [7:0] hend);
    if (steps >= StepW'(MAX_OPTION_STEPS) || off >= hend) begin
      return PhDone;
    end
    return PhKind;
  endfunction

  assign out_free     = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && (!item_i.last || out_free);
  assign frame_end    = pop && item_i.last;
  assign item_ready_o = pop;

  assign b         = item_i.data;
  assign p         = item_i.offset;
  assign tcp_rel   = p - tcp_off_q;
  assign room      = hdr_end_q - next_off_q;
  assign ihl_bytes = {b[3:0], 2'b00};
  assign thb_bytes = {b[7:4], 2'b00};
  assign steps_inc = steps_q + StepW'(1);

  // Next state: one byte per popped transaction.
  always_comb begin
    phase_d    = phase_q;
    verdict_d  = verdict_q;
    kind_d     = kind_q;
    tcp_off_d  = tcp_off_q;
    hdr_end_d  = hdr_end_q;
    next_off_d = next_off_q;
    steps_d    = steps_q;
    addr_d     = addr_q;
    ports_d    = ports_q;
    value_d    = value_q;
    if (pop) begin
      unique case (phase_q)
        PhHeader: begin
          case (item_i.cls)
            ClsEthHi: kind_d = b;
            ClsEthLo: begin
              if ({kind_q, b} != cfg_i.ether_type) begin
                phase_d   = PhDone;
                verdict_d = StNotIpv4;
              end
            end
            ClsVerIhl: begin
              if ((b & VersionMask) != Version4 || ihl_bytes < MinHeaderBytes) begin
                phase_d   = PhDone;
                verdict_d = StNotIpv4;
              end else begin
                tcp_off_d = 8'(L2_HEADER_BYTES) + {2'b00, ihl_bytes};
              end
            end
            ClsProto: begin
              if (b != TcpProtoNumber) begin
                phase_d   = PhDone;
                verdict_d = StNotTcp;
              end
            end
            ClsAddr: addr_d = {addr_q[55:0], b};
            ClsL4: begin
              if (p >= tcp_off_q) begin
                if (tcp_rel < 8'd4) begin
                  ports_d = {ports_q[23:0], b};
                end else if (tcp_rel == 8'd12) begin
                  if (thb_bytes < MinHeaderBytes) begin
                    phase_d   = PhDone;
                    verdict_d = StBadOffset;
                  end else begin
                    hdr_end_d = tcp_off_q + {2'b00, thb_bytes};
                  end
                end else if (tcp_rel == 8'd13) begin
                  if ((b & AckMask) == 8'd0) begin
                    phase_d   = PhDone;
                    verdict_d = StNoAck;
                  end else begin
                    next_off_d = tcp_off_q + FixedTcpBytes;
                    phase_d    = walk_phase(tcp_off_q + FixedTcpBytes, steps_q, hdr_end_q);
                  end
                end
              end
            end
            default: ;
          endcase
        end
        PhKind: begin
          if (p == next_off_q) begin
            steps_d = steps_inc;
            if (b == OptEol) begin
              phase_d = PhDone;
            end else if (b == OptNop) begin
              next_off_d = next_off_q + 8'd1;
              phase_d    = walk_phase(next_off_q + 8'd1, steps_inc, hdr_end_q);
            end else if ({1'b0, next_off_q} + 9'd2 > {1'b0, hdr_end_q}) begin
              // The kind byte is the last header byte.
              phase_d = PhDone;
            end else begin
              kind_d  = b;
              phase_d = PhLen;
            end
          end
        end
        PhLen: begin
          if (b < OptionMinLen || b > room) begin
            phase_d = PhDone;
          end else if (kind_q == cfg_i.option_kind && b == ValueOptionLen) begin
            value_d = '0;
            phase_d = PhValue;
          end else if (b == OptionMinLen) begin
            next_off_d = next_off_q + 8'd2;
            phase_d    = walk_phase(next_off_q + 8'd2, steps_q, hdr_end_q);
          end else begin
            next_off_d = next_off_q + b;
            phase_d    = PhSkip;
          end
        end
        PhSkip: begin
          if ({1'b0, p} + 9'd1 >= {1'b0, next_off_q}) begin
            phase_d = walk_phase(next_off_q, steps_q, hdr_end_q);
          end
        end
        PhValue: begin
          value_d = {value_q[55:0], b};
          if ({1'b0, p} >= {1'b0, next_off_q} + 9'd9) begin
            phase_d   = PhDone;
            verdict_d = StFound;
          end
        end
        PhDone: ;
        default: ;
      endcase
    end
  end

  // Outputs: the result is built from the state after the final byte.
  always_comb begin
    status            = (phase_d == PhDone) ? verdict_d : StTruncated;
    out_d             = out_q;
    out_valid_d       = out_valid_q;
    if (frame_end) begin
      out_valid_d       = 1'b1;
      out_d.status      = status;
      out_d.src_addr    = addr_d[63:32];
      out_d.dst_addr    = addr_d[31:0];
      out_d.src_port    = ports_d[31:16];
      out_d.dst_port    = ports_d[15:0];
      out_d.numerator   = (status == StFound) ? value_d[63:32] : 32'd0;
      out_d.denominator = (status == StFound) ? value_d[31:0] : 32'd0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= PhHeader;
      verdict_q   <= StAbsent;
      kind_q      <= '0;
      tcp_off_q   <= '0;
      hdr_end_q   <= '0;
      next_off_q  <= '0;
      steps_q     <= '0;
      addr_q      <= '0;
      ports_q     <= '0;
      value_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (frame_end) begin
        phase_q    <= PhHeader;
        verdict_q  <= StAbsent;
        kind_q     <= '0;
        tcp_off_q  <= '0;
        hdr_end_q  <= '0;
        next_off_q <= '0;
        steps_q    <= '0;
        addr_q     <= '0;
        ports_q    <= '0;
        value_q    <= '0;
      end else begin
        phase_q    <= phase_d;
        verdict_q  <= verdict_d;
        kind_q     <= kind_d;
        tcp_off_q  <= tcp_off_d;
        hdr_end_q  <= hdr_end_d;
        next_off_q <= next_off_d;
        steps_q    <= steps_d;
        addr_q     <= addr_d;
        ports_q    <= ports_d;
        value_q    <= value_d;
      end
    end
  end

endmodule

/* design/tcp_option_value_extractor_unit.sv */
// Top level of the TCP option value extractor.
`timescale 1ns / 1ps
`include "tcp_option_value_extractor_unit_assert.svh"

// Usage: an Ethernet frame enters on the s_axis channel one byte per
// transaction, wire order, with tlast on its final byte. For every frame one
// result transaction leaves on the m_axis channel: status, IPv4 addresses,
// TCP ports and the two 32-bit values of the first option whose kind matches
// the option_kind register and whose length is 10.
// Registers are written on the cfg channel (index 0 option_kind, index 1
// ether_type); writes to other indexes are dropped. The user must write them
// only while no frame is in flight; the block itself does not enforce this.
// Throughput is one byte per cycle while the result register is free: the
// ingress stage tags every byte with its offset, a four-entry queue holds it,
// and the parser takes one byte a cycle. The result sits in an output
// register and is valid in the cycle after the parser takes the final byte;
// while the receiver holds tready low the parser keeps taking bytes of the
// next frame and stops only at that frame's final byte, after which the queue
// fills and s_axis_tready_o drops. Reset clears the queue, the parse state and
// the output valid flag and restores option_kind to 253 and ether_type to 0x0800.
module tcp_option_value_extractor_unit import tove_pkg::*; #(
  parameter int unsigned L2_HEADER_BYTES  = 14,
  parameter int unsigned MAX_OPTION_STEPS = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // data_byte [7:0]
  input  logic                 s_axis_tlast_i,   // last_byte
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // status [2:0], src_addr [34:3], dst_addr [66:35], src_port [82:67],
  // dst_port [98:83], numerator [130:99], denominator [162:131], zero above
  output logic [TdataW-1:0]    m_axis_tdata_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  cfg_t        cfg_q;
  logic        push_valid, push_ready;
  queue_item_t push_item;
  logic        q_valid, q_pop;
  queue_item_t q_item;
  result_t     m_result;

  // The register file is always ready for a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.option_kind <= ResetOptionKind;
      cfg_q.ether_type  <= ResetEtherType;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgOptionKind: cfg_q.option_kind <= cfg_data_i[7:0];
        CfgEtherType:  cfg_q.ether_type  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tove_front #(
    .L2_HEADER_BYTES(L2_HEADER_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  tove_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_item_i  (push_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_pop),
    .rd_item_o  (q_item)
  );

  tove_parser #(
    .L2_HEADER_BYTES (L2_HEADER_BYTES),
    .MAX_OPTION_STEPS(MAX_OPTION_STEPS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_ready_o (q_pop),
    .item_i       (q_item),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (m_result)
  );

  assign m_axis_tdata_o = {{(TdataW - ResultW){1'b0}}, m_result};

  // A final byte taken by the parser always produces a result next cycle.
  `TOVE_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, q_pop && q_item.last, m_axis_tvalid_o, "final byte did not produce a result")
  // A stalled result is never overwritten by the next frame.
  `TOVE_ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, !(q_pop && q_item.last), "stalled result overwritten")
  // The option values are zero unless the option was found.
  `TOVE_ASSERT_IMPLIES(a_values_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_result.status != StFound), (m_result.numerator == 32'd0) && (m_result.denominator == 32'd0), "option values leak without a match")

endmodule
